// ===== rtl/gbba_pkg.sv =====
// ----------------------------------------------------------------------------
// Grouped bitmap block allocator package
// Sizes that the core and the bitmap memory share, and the codes, state
// encoding and bit search that the core uses.
// ----------------------------------------------------------------------------
package gbba_pkg;

  localparam int MAX_GROUPS       = 8;
  localparam int BLOCKS_PER_GROUP = 8192;
  localparam int WORD_BITS        = 32;

  localparam int BLK_W   = 16;
  localparam int CNT_W   = 14;
  localparam int GIN_W   = 4;
  localparam int GRP_W   = $clog2(MAX_GROUPS);
  localparam int IDX_W   = $clog2(BLOCKS_PER_GROUP);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WIDX_W  = IDX_W - BIT_W;
  localparam int ADDR_W  = GRP_W + WIDX_W;
  localparam int DEPTH   = MAX_GROUPS * (BLOCKS_PER_GROUP / WORD_BITS);

  localparam logic [CNT_W-1:0]     CNT_INIT   = CNT_W'(BLOCKS_PER_GROUP);
  localparam logic [GIN_W-1:0]     GIN_MAX    = GIN_W'(MAX_GROUPS);
  localparam logic [GIN_W-1:0]     GIN_RESET  = GIN_W'(8);
  localparam logic [WORD_BITS-1:0] WORD_ONE   = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] WORD_FULL  = '1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_ALREADY  = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FSEL,
    ST_SCAN,
    ST_FCHK,
    ST_RESP
  } state_t;

  // Position of the lowest clear bit of a word that is not all ones.
  function automatic logic [BIT_W-1:0] first_zero(input word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/gbba_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// Bitmap memory
// Single-port-write, single-port-read synchronous memory holding the used
// block bitmap, with registered read data.
// ----------------------------------------------------------------------------
module gbba_bitmap_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [gbba_pkg::ADDR_W-1:0]  wr_addr,
  input  gbba_pkg::word_t              wr_data,
  input  logic                         rd_en,
  input  logic [gbba_pkg::ADDR_W-1:0]  rd_addr,
  output gbba_pkg::word_t              rd_data
);
  import gbba_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/grouped_bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Grouped bitmap block allocator core
// Allocates and frees blocks of a grouped used-block bitmap with a free
// count for each group.
// ----------------------------------------------------------------------------
// After reset the core clears the bitmap memory one word a cycle and holds
// in_stall high meanwhile; the configuration port is open at all times. A free
// request reads the bitmap word of its block and writes it back with the bit
// cleared, or goes straight to the response when the block is out of range. An
// allocate request passes over groups with a free count of zero and, for the
// chosen group, reads one bitmap word at a time through the single read port of
// the bitmap memory until a word with a clear bit returns, at most 256 words.
// One request is worked on at a time and the result waits in an output
// register.
module grouped_bitmap_block_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [gbba_pkg::BLK_W-1:0]    in_block_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gbba_pkg::BLK_W-1:0]    out_allocated_block,
  output logic [1:0]                    out_status,
  output logic [gbba_pkg::CNT_W-1:0]    out_group_free_left,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbba_pkg::GIN_W-1:0]    cfg_groups_in_use
);
  import gbba_pkg::*;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  logic [GRP_W:0]       g_r, g_nxt;
  logic [WIDX_W:0]      iss_r, iss_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     blk_r, blk_nxt;
  logic [BLK_W-1:0]     res_alloc_r, res_alloc_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [CNT_W-1:0]     res_left_r, res_left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]     out_alloc_r, out_alloc_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_left_r, out_left_nxt;
  logic [GIN_W-1:0]     gin_r;
  logic [CNT_W-1:0]     cnt_r [MAX_GROUPS];

  logic                 wr_en, rd_en, cnt_we;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  word_t                wr_data, rd_data;
  logic [CNT_W-1:0]     cnt_wdata, cnt_cur, cnt_inc;
  logic [GIN_W-1:0]     ng;
  logic [GRP_W-1:0]     grp;
  logic [WIDX_W-1:0]    dwidx;
  logic [BIT_W-1:0]     zbit;

  gbba_bitmap_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready           = 1'b1;
  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_allocated_block = out_alloc_r;
  assign out_status          = out_status_r;
  assign out_group_free_left = out_left_r;

  assign ng      = (gin_r > GIN_MAX) ? GIN_MAX : gin_r;
  assign grp     = g_r[GRP_W-1:0];
  assign cnt_cur = cnt_r[grp];
  assign cnt_inc = (cnt_cur < CNT_INIT) ? cnt_cur + CNT_W'(1) : cnt_cur;
  assign dwidx   = iss_r[WIDX_W-1:0] - WIDX_W'(1);
  assign zbit    = first_zero(rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      gin_r       <= GIN_RESET;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        cnt_r[i] <= CNT_INIT;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        gin_r <= cfg_groups_in_use;
      end
      if (cnt_we) begin
        cnt_r[grp] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    iss_r        <= iss_nxt;
    pend_r       <= pend_nxt;
    blk_r        <= blk_nxt;
    res_alloc_r  <= res_alloc_nxt;
    res_status_r <= res_status_nxt;
    res_left_r   <= res_left_nxt;
    out_alloc_r  <= out_alloc_nxt;
    out_status_r <= out_status_nxt;
    out_left_r   <= out_left_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    g_nxt          = g_r;
    iss_nxt        = iss_r;
    pend_nxt       = pend_r;
    blk_nxt        = blk_r;
    res_alloc_nxt  = res_alloc_r;
    res_status_nxt = res_status_r;
    res_left_nxt   = res_left_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_alloc_nxt  = out_alloc_r;
    out_status_nxt = out_status_r;
    out_left_nxt   = out_left_r;
    wr_en          = 1'b0;
    wr_addr        = clr_r;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = {grp, iss_r[WIDX_W-1:0]};
    cnt_we         = 1'b0;
    cnt_wdata      = cnt_cur;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_FREE) begin
            if ({1'b0, in_block_number[BLK_W-1:IDX_W]} >= ng) begin
              res_alloc_nxt  = '0;
              res_status_nxt = STAT_RANGE;
              res_left_nxt   = '0;
              state_nxt      = ST_RESP;
            end else begin
              g_nxt     = {1'b0, in_block_number[BLK_W-1:IDX_W]};
              blk_nxt   = in_block_number[IDX_W-1:0];
              rd_en     = 1'b1;
              rd_addr   = in_block_number[BLK_W-1:BIT_W];
              state_nxt = ST_FCHK;
            end
          end else begin
            g_nxt     = '0;
            state_nxt = ST_FSEL;
          end
        end
      end
      ST_FSEL: begin
        if (g_r >= ng) begin
          res_alloc_nxt  = '0;
          res_status_nxt = STAT_NO_SPACE;
          res_left_nxt   = '0;
          state_nxt      = ST_RESP;
        end else if (cnt_cur == '0) begin
          g_nxt = g_r + (GRP_W+1)'(1);
        end else begin
          iss_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_r && (rd_data != WORD_FULL)) begin
          wr_en          = 1'b1;
          wr_addr        = {grp, dwidx};
          wr_data        = rd_data | (WORD_ONE << zbit);
          cnt_we         = 1'b1;
          cnt_wdata      = cnt_cur - CNT_W'(1);
          res_alloc_nxt  = {grp, dwidx, zbit};
          res_status_nxt = STAT_OK;
          res_left_nxt   = cnt_cur - CNT_W'(1);
          state_nxt      = ST_RESP;
        end else if (iss_r[WIDX_W]) begin
          g_nxt     = g_r + (GRP_W+1)'(1);
          state_nxt = ST_FSEL;
        end else begin
          rd_en    = 1'b1;
          iss_nxt  = iss_r + (WIDX_W+1)'(1);
          pend_nxt = 1'b1;
        end
      end
      ST_FCHK: begin
        res_alloc_nxt = '0;
        if (!rd_data[blk_r[BIT_W-1:0]]) begin
          res_status_nxt = STAT_ALREADY;
          res_left_nxt   = cnt_cur;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = {grp, blk_r[IDX_W-1:BIT_W]};
          wr_data        = rd_data & ~(WORD_ONE << blk_r[BIT_W-1:0]);
          cnt_we         = 1'b1;
          cnt_wdata      = cnt_inc;
          res_status_nxt = STAT_OK;
          res_left_nxt   = cnt_inc;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_alloc_nxt  = res_alloc_r;
          out_status_nxt = res_status_r;
          out_left_nxt   = res_left_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Grouped bitmap block allocator testbench
// Drives allocate and free requests into the core, a directed table then
// random traffic over several group counts, and checks every result against
// its table row or a model of the group bitmaps and free counts kept here.
// ----------------------------------------------------------------------------
module testbench;
  import gbba_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int TAIL_CYCLES = 300;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 71;
  localparam int ROWS        = 25;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_t          status;
    logic [CNT_W-1:0] left;
  } alloc_result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [GIN_W-1:0] groups;
    func_t            func;
    logic [BLK_W-1:0] blk;
    logic             typed;
    alloc_result_t    res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic [BLK_W-1:0]   in_block_number = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BLK_W-1:0]   out_allocated_block;
  logic [1:0]         out_status;
  logic [CNT_W-1:0]   out_group_free_left;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [GIN_W-1:0]   cfg_groups_in_use = '0;

  bit                 used_map [MAX_GROUPS][BLOCKS_PER_GROUP];
  int unsigned        free_cnt [MAX_GROUPS];
  logic [GIN_W-1:0]   groups_cfg = GIN_RESET;

  alloc_result_t      pending_results [$];
  logic [BLK_W-1:0]   granted_blocks [$];
  stim_row_t          directed_rows [ROWS];
  int                 send_idle_pct = 37;
  int                 recv_idle_pct = 60;
  int                 err_count = 0;
  int                 cycles = 0;

  grouped_bitmap_block_allocator_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_allocated_block (out_allocated_block),
    .out_status          (out_status),
    .out_group_free_left (out_group_free_left),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_groups_in_use   (cfg_groups_in_use)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("cycle %0d: %s", cycles, msg);
    err_count++;
  endtask

  function automatic alloc_result_t predict_allocator(input func_t f,
                                                      input logic [BLK_W-1:0] b);
    alloc_result_t res;
    int            ng;
    int            idx;
    int            g;
    res = '0;
    ng  = (groups_cfg > GIN_MAX) ? MAX_GROUPS : int'(groups_cfg);
    if (f == FUNC_ALLOC) begin
      res.status = STAT_NO_SPACE;
      for (g = 0; g < ng; g++) begin
        if (free_cnt[g] == 0) continue;
        idx = BLOCKS_PER_GROUP;
        for (int i = 0; i < BLOCKS_PER_GROUP; i++) begin
          if (!used_map[g][i]) begin
            idx = i;
            break;
          end
        end
        if (idx == BLOCKS_PER_GROUP) continue;
        used_map[g][idx] = 1'b1;
        free_cnt[g]--;
        res.blk    = BLK_W'(g * BLOCKS_PER_GROUP + idx);
        res.status = STAT_OK;
        res.left   = CNT_W'(free_cnt[g]);
        break;
      end
    end else if (int'(b) >= ng * BLOCKS_PER_GROUP) begin
      res.status = STAT_RANGE;
    end else begin
      g   = int'(b) / BLOCKS_PER_GROUP;
      idx = int'(b) % BLOCKS_PER_GROUP;
      if (!used_map[g][idx]) begin
        res.status = STAT_ALREADY;
      end else begin
        used_map[g][idx] = 1'b0;
        res.status = STAT_OK;
        if (free_cnt[g] < BLOCKS_PER_GROUP) free_cnt[g]++;
      end
      res.left = CNT_W'(free_cnt[g]);
    end
    return res;
  endfunction

  task automatic issue_request(input func_t f, input logic [BLK_W-1:0] b,
                               input logic typed, input alloc_result_t typed_res,
                               output alloc_result_t pred);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_block_number <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = predict_allocator(f, b);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_groups(input logic [GIN_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_groups_in_use <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    groups_cfg  = v;
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result block %0d status %0d",
                                  out_allocated_block, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_allocated_block !== want.blk)
          report_mismatch($sformatf("allocated_block got %0d expected %0d",
                                    out_allocated_block, want.blk));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    out_status, want.status));
        if (out_group_free_left !== want.left)
          report_mismatch($sformatf("group_free_left got %0d expected %0d",
                                    out_group_free_left, want.left));
      end
    end
  end

  initial begin : stimulus
    alloc_result_t    pred;
    func_t            f;
    logic [BLK_W-1:0] b;
    logic [GIN_W-1:0] seg_groups [SEGMENTS];
    int               r;
    int               pick;

    for (int g = 0; g < MAX_GROUPS; g++) free_cnt[g] = BLOCKS_PER_GROUP;
    seg_groups = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd8,
                   4'd6, 4'd1, 4'd2, 4'd8, 4'd15, 4'd5};
    directed_rows = '{
      '{ROW_REQ, 4'd0,  FUNC_ALLOC, 16'd0,     1'b1, '{16'd0, STAT_OK,       14'd8191}},
      '{ROW_REQ, 4'd0,  FUNC_ALLOC, 16'hFFFF,  1'b1, '{16'd1, STAT_OK,       14'd8190}},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd0,     1'b1, '{16'd0, STAT_OK,       14'd8191}},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd0,     1'b1, '{16'd0, STAT_ALREADY,  14'd8191}},
      '{ROW_REQ, 4'd0,  FUNC_ALLOC, 16'd0,     1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd65535, 1'b1, '{16'd0, STAT_ALREADY,  14'd8192}},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd8192,  1'b1, '{16'd0, STAT_ALREADY,  14'd8192}},
      '{ROW_CFG, 4'd1,  FUNC_ALLOC, 16'd0,     1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd8192,  1'b1, '{16'd0, STAT_RANGE,    14'd0}},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd65535, 1'b1, '{16'd0, STAT_RANGE,    14'd0}},
      '{ROW_REQ, 4'd0,  FUNC_ALLOC, 16'd0,     1'b0, '0},
      '{ROW_CFG, 4'd0,  FUNC_ALLOC, 16'd0,     1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_ALLOC, 16'd0,     1'b1, '{16'd0, STAT_NO_SPACE, 14'd0}},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd0,     1'b1, '{16'd0, STAT_RANGE,    14'd0}},
      '{ROW_CFG, 4'd15, FUNC_ALLOC, 16'd0,     1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd65535, 1'b1, '{16'd0, STAT_ALREADY,  14'd8192}},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd1,     1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_ALLOC, 16'h5A5A,  1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'h5555,  1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'hAAAA,  1'b0, '0},
      '{ROW_CFG, 4'd4,  FUNC_ALLOC, 16'd0,     1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd32767, 1'b0, '0},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd32768, 1'b1, '{16'd0, STAT_RANGE,    14'd0}},
      '{ROW_REQ, 4'd0,  FUNC_FREE,  16'd2,     1'b0, '0},
      '{ROW_CFG, 4'd8,  FUNC_ALLOC, 16'd0,     1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < ROWS; row++) begin
      if (directed_rows[row].kind == ROW_CFG) begin
        write_groups(directed_rows[row].groups);
      end else begin
        issue_request(directed_rows[row].func, directed_rows[row].blk,
                      directed_rows[row].typed, directed_rows[row].res, pred);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_groups(seg_groups[seg]);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        f = FUNC_FREE;
        if (r < 50 || granted_blocks.size() == 0) begin
          f = FUNC_ALLOC;
          b = BLK_W'($urandom);
        end else if (r < 80) begin
          pick = $urandom_range(0, granted_blocks.size() - 1);
          b    = granted_blocks[pick];
        end else if (r < 90) begin
          b = BLK_W'($urandom_range(0, 1023));
        end else begin
          b = BLK_W'($urandom);
        end
        issue_request(f, b, 1'b0, '0, pred);
        if (pred.status == STAT_OK) begin
          if (f == FUNC_ALLOC) begin
            granted_blocks.push_back(pred.blk);
          end else begin
            for (int i = 0; i < granted_blocks.size(); i++) begin
              if (granted_blocks[i] == b) begin
                granted_blocks.delete(i);
                break;
              end
            end
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gbba_pkg.sv
rtl/gbba_bitmap_ram.sv
rtl/grouped_bitmap_block_allocator_core.sv
tb/testbench.sv
